/* sv/qrbc_pkg.sv */
// Shared types, constants and mask helpers for the QR module bit classifier.
package qrbc_pkg;

  // Stream layout of one input item
  localparam int unsigned POS_W       = 8;
  localparam int unsigned SAMPLE_W    = 12;
  localparam int unsigned NUM_SAMPLES = 5;
  localparam int unsigned ROW_LSB     = 0;
  localparam int unsigned COL_LSB     = 8;
  localparam int unsigned SAMPLE_LSB  = 16;
  localparam int unsigned ENTRY_W     = SAMPLE_LSB + NUM_SAMPLES * SAMPLE_W;
  localparam int unsigned QIDX_LSB    = ENTRY_W;
  localparam int unsigned QIDX_W      = 15;
  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned OP_W        = 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned THR_W      = 12;
  localparam int unsigned MC_W       = 8;
  localparam int unsigned MASK_W     = 3;

  localparam logic [THR_W-1:0]  THR_RESET  = 12'd2048;
  localparam logic [MC_W-1:0]   MC_RESET   = 8'd21;
  localparam logic [MASK_W-1:0] MASK_RESET = 3'd0;

  // Lower-right region and voting
  localparam int unsigned REGION_MIN_START   = 8;
  localparam int unsigned REGION_EDGE_OFFSET = 10;
  localparam int unsigned VOTES_FOR_ONE      = 3;

  // Divide an 8-bit value by 3 as (v * 171) >> 9
  localparam int unsigned DIV3_MUL   = 171;
  localparam int unsigned DIV3_SHIFT = 9;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CORNER = 3'd0,
    CFG_RIGHT  = 3'd1,
    CFG_DOWN   = 3'd2,
    CFG_COUNT  = 3'd3,
    CFG_MASK   = 3'd4
  } cfg_idx_t;

  typedef enum logic [MASK_W-1:0] {
    MASK_SUM2   = 3'd0,
    MASK_ROW2   = 3'd1,
    MASK_COL3   = 3'd2,
    MASK_SUM3   = 3'd3,
    MASK_BLOCK  = 3'd4,
    MASK_PROD   = 3'd5,
    MASK_PALT   = 3'd6,
    MASK_MIXED  = 3'd7
  } mask_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic clear;
    logic query;
    logic out_load;
  } cmd_t;

  // Quotient of an 8-bit value by 3
  function automatic logic [POS_W-1:0] div3(input logic [POS_W-1:0] v);
    logic [16:0] prod;
    prod = 17'(v) * 17'(DIV3_MUL);
    return prod[DIV3_SHIFT +: POS_W];
  endfunction

  // Remainder of an 8-bit value by 3
  function automatic logic [1:0] mod3(input logic [POS_W-1:0] v);
    logic [9:0] back;
    back = 10'(div3(v)) * 10'd3;
    return 2'(10'(v) - back);
  endfunction

  // Reduce a value in 0..4 modulo 3
  function automatic logic [1:0] fold3(input logic [2:0] v);
    logic [2:0] r;
    r = (v >= 3'd3) ? v - 3'd3 : v;
    return r[1:0];
  endfunction

  // Standard QR data mask bit for row i, column j
  function automatic logic mask_flip(input logic [POS_W-1:0] i, input logic [POS_W-1:0] j,
                                     input logic [MASK_W-1:0] pattern);
    logic [1:0]       i3;
    logic [1:0]       j3;
    logic [1:0]       sum3;
    logic [1:0]       prod3;
    logic             prod2;
    logic [POS_W-1:0] jd3;
    logic             flip;
    i3    = mod3(i);
    j3    = mod3(j);
    jd3   = div3(j);
    sum3  = fold3(3'(i3) + 3'(j3));
    prod3 = fold3(3'(4'(i3) * 4'(j3)));
    prod2 = i[0] & j[0];
    unique case (mask_t'(pattern))
      MASK_SUM2:  flip = ~(i[0] ^ j[0]);
      MASK_ROW2:  flip = ~i[0];
      MASK_COL3:  flip = (j3 == 2'd0);
      MASK_SUM3:  flip = (sum3 == 2'd0);
      MASK_BLOCK: flip = ~(i[1] ^ jd3[0]);
      MASK_PROD:  flip = ~prod2 && (prod3 == 2'd0);
      MASK_PALT:  flip = ~(prod2 ^ prod3[0]);
      MASK_MIXED: flip = ~(i[0] ^ j[0] ^ prod3[0]);
    endcase
    return flip;
  endfunction

endpackage

/* sv/qrbc_ctrl.sv */
// Controller: stream handshakes and the step sequence of a bit query.
module qrbc_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [qrbc_pkg::OP_W-1:0]    s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output qrbc_pkg::cmd_t               cmd
);
  import qrbc_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PROD  = 7'b0000010,
    ST_SCALE = 7'b0000100,
    ST_SUM   = 7'b0001000,
    ST_NORM  = 7'b0010000,
    ST_RHS   = 7'b0100000,
    ST_VOTE  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_free;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Decode the accepted item into datapath commands
  always_comb begin
    cmd.load     = accept && (op_t'(s_tuser) == OP_LOAD);
    cmd.clear    = accept && (op_t'(s_tuser) == OP_CLEAR);
    cmd.query    = accept && (op_t'(s_tuser) == OP_QUERY);
    cmd.out_load = (state == ST_VOTE) && out_free;
  end

  // Walk the query through the datapath stages
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (cmd.query) state_next = ST_PROD;
      ST_PROD:  state_next = ST_SCALE;
      ST_SCALE: state_next = ST_SUM;
      ST_SUM:   state_next = ST_NORM;
      ST_NORM:  state_next = ST_RHS;
      ST_RHS:   state_next = ST_VOTE;
      ST_VOTE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result register overwritten while a transfer is pending");

  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.query |=> (state == ST_PROD) && !s_tready)
    else $error("query did not start the step sequence");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("loaded result not offered");

endmodule

/* sv/qrbc_dp.sv */
// Datapath: configuration, module store, lower-right sums and threshold pipeline.
module qrbc_dp #(
  parameter int unsigned MAX_BITS = 32768
) (
  input  logic                                clk,
  input  logic                                rst,
  input  qrbc_pkg::cmd_t                      cmd,
  input  logic [qrbc_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic                                cfg_we,
  input  logic [qrbc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qrbc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [qrbc_pkg::OUT_TDATA_W-1:0]    m_tdata
);
  import qrbc_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_BITS + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_BITS);
  localparam int unsigned CMP_W  = (CNT_W > QIDX_W) ? CNT_W : QIDX_W;
  localparam int unsigned SUM_W  = $clog2(MAX_BITS * NUM_SAMPLES * 4095 + 1);
  localparam int unsigned NS_W   = $clog2(MAX_BITS * NUM_SAMPLES + 1);
  localparam int unsigned Q_W    = SUM_W + 2 * POS_W;
  localparam int unsigned L_W    = SAMPLE_W + 2 * POS_W;
  localparam int unsigned LHS_W  = L_W + NS_W;
  localparam int unsigned RHS_W  = NS_W + 32;

  // Configuration registers
  logic [THR_W-1:0]  corner_thr;
  logic [THR_W-1:0]  right_thr;
  logic [THR_W-1:0]  down_thr;
  logic [MC_W-1:0]   module_count;
  logic [MASK_W-1:0] mask_pattern;

  // Store state
  logic [ENTRY_W-1:0] mem [MAX_BITS];
  logic [CNT_W-1:0]   loaded_count;
  logic [SUM_W-1:0]   lr_sum;
  logic [NS_W-1:0]    lr_samples;
  logic               full;
  logic [MC_W-1:0]    region_start;
  logic               in_region;
  logic [14:0]        load_sum;
  logic [QIDX_W-1:0]  query_index;

  // Query pipeline
  logic [ENTRY_W-1:0]       rd_word;
  logic                     qvalid;
  logic [POS_W-1:0]         rd_row;
  logic [POS_W-1:0]         rd_col;
  logic [MC_W-1:0]          g;
  logic signed [8:0]        gc;
  logic signed [8:0]        gr;
  logic signed [17:0]       p1;
  logic signed [17:0]       p2;
  logic signed [17:0]       p3;
  logic [15:0]              p4;
  logic [15:0]              gg;
  logic [NS_W-1:0]          n_eff;
  logic [SUM_W-1:0]         s_eff;
  logic                     mask_bit;
  logic signed [28:0]       t1;
  logic signed [28:0]       t2;
  logic signed [28:0]       t3;
  logic [Q_W-1:0]           q;
  logic [L_W-1:0]           l [NUM_SAMPLES];
  logic signed [30:0]       a_sum;
  logic signed [RHS_W-1:0]  n_a;
  logic [LHS_W-1:0]         lhs [NUM_SAMPLES];
  logic signed [RHS_W-1:0]  rhs;
  logic [NUM_SAMPLES-1:0]   below;
  logic [2:0]               votes;
  logic                     out_bit;
  logic                     out_ivalid;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      corner_thr   <= THR_RESET;
      right_thr    <= THR_RESET;
      down_thr     <= THR_RESET;
      module_count <= MC_RESET;
      mask_pattern <= MASK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CORNER: corner_thr   <= cfg_data[THR_W-1:0];
        CFG_RIGHT:  right_thr    <= cfg_data[THR_W-1:0];
        CFG_DOWN:   down_thr     <= cfg_data[THR_W-1:0];
        CFG_COUNT:  module_count <= cfg_data[MC_W-1:0];
        CFG_MASK:   mask_pattern <= cfg_data[MASK_W-1:0];
        default:    ;
      endcase
    end
  end

  // Region test and sample sum of a loaded module
  always_comb begin
    full         = (loaded_count == CNT_W'(MAX_BITS));
    region_start = (module_count < MC_W'(REGION_MIN_START + REGION_EDGE_OFFSET))
                   ? MC_W'(REGION_MIN_START) : module_count - MC_W'(REGION_EDGE_OFFSET);
    in_region    = (s_tdata[ROW_LSB +: POS_W] >= region_start) ||
                   (s_tdata[COL_LSB +: POS_W] >= region_start);
    load_sum     = '0;
    for (int k = 0; k < NUM_SAMPLES; k++) begin
      load_sum = load_sum + 15'(s_tdata[SAMPLE_LSB + k * SAMPLE_W +: SAMPLE_W]);
    end
    query_index  = s_tdata[QIDX_LSB +: QIDX_W];
  end

  // Count loads and accumulate the lower-right samples
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      loaded_count <= '0;
      lr_sum       <= '0;
      lr_samples   <= '0;
    end else if (cmd.load && !full) begin
      loaded_count <= loaded_count + CNT_W'(1);
      if (in_region) begin
        lr_sum     <= lr_sum + SUM_W'(load_sum);
        lr_samples <= lr_samples + NS_W'(NUM_SAMPLES);
      end
    end
  end

  // Module store: write on load, registered read on query
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[loaded_count[ADDR_W-1:0]] <= s_tdata[ENTRY_W-1:0];
    end
    if (cmd.query) begin
      rd_word <= mem[ADDR_W'(query_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query) begin
      qvalid <= (CMP_W'(query_index) < CMP_W'(loaded_count));
    end
  end

  // Grid span and signed weights
  always_comb begin
    rd_row = rd_word[ROW_LSB +: POS_W];
    rd_col = rd_word[COL_LSB +: POS_W];
    g      = (module_count < MC_W'(2)) ? MC_W'(1) : module_count - MC_W'(1);
    gc     = $signed({1'b0, g}) - $signed({1'b0, rd_col});
    gr     = $signed({1'b0, g}) - $signed({1'b0, rd_row});
  end

  // Stage one: weight products, span square, effective lower-right terms, mask
  always_ff @(posedge clk) begin
    p1       <= gc * gr;
    p2       <= $signed({1'b0, rd_col}) * gr;
    p3       <= gc * $signed({1'b0, rd_row});
    p4       <= 16'(rd_col) * 16'(rd_row);
    gg       <= 16'(g) * 16'(g);
    n_eff    <= (lr_samples == '0) ? NS_W'(1) : lr_samples;
    s_eff    <= (lr_samples == '0) ? SUM_W'(corner_thr) : lr_sum;
    mask_bit <= mask_flip(rd_row, rd_col, mask_pattern);
  end

  // Stage two: scale by the corner thresholds and the span square
  always_ff @(posedge clk) begin
    t1 <= p1 * $signed({1'b0, corner_thr});
    t2 <= p2 * $signed({1'b0, right_thr});
    t3 <= p3 * $signed({1'b0, down_thr});
    q  <= Q_W'(p4) * Q_W'(s_eff);
    for (int k = 0; k < NUM_SAMPLES; k++) begin
      l[k] <= L_W'(rd_word[SAMPLE_LSB + k * SAMPLE_W +: SAMPLE_W]) * L_W'(gg);
    end
  end

  // Stage three: add the three corner terms
  always_ff @(posedge clk) begin
    a_sum <= 31'(t1) + 31'(t2) + 31'(t3);
  end

  // Stage four: scale by the sample count
  always_ff @(posedge clk) begin
    n_a <= $signed({1'b0, n_eff}) * a_sum;
    for (int k = 0; k < NUM_SAMPLES; k++) begin
      lhs[k] <= LHS_W'(l[k]) * LHS_W'(n_eff);
    end
  end

  // Stage five: complete the scaled threshold
  always_ff @(posedge clk) begin
    rhs <= n_a + $signed(RHS_W'(q));
  end

  // Compare each sample and count votes
  always_comb begin
    votes = '0;
    for (int k = 0; k < NUM_SAMPLES; k++) begin
      below[k] = $signed(RHS_W'(lhs[k])) < rhs;
      votes    = votes + 3'(below[k]);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ivalid <= qvalid;
      out_bit    <= qvalid && ((votes >= 3'(VOTES_FOR_ONE)) ^ mask_bit);
    end
  end

  assign m_tdata = {(OUT_TDATA_W - 2)'(0), out_ivalid, out_bit};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    loaded_count <= CNT_W'(MAX_BITS))
    else $error("load count ran past the store depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (loaded_count == '0) && (lr_samples == '0) && (lr_sum == '0))
    else $error("clear left store state behind");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && !qvalid) |=> !out_bit && !out_ivalid)
    else $error("query beyond the count returned a set bit");

endmodule

/* sv/qr_module_bit_classifier.sv */
// Top level of the QR module bit classifier: controller plus datapath.
//
// Input stream (s_*): each transfer carries an operation in s_tuser. A load
// stores a module's row, column and five samples in arrival order and adds
// the samples to the lower-right average when the module lies in that region.
// A clear empties the store. A query returns one result on the output stream
// (m_*): the voted, masked bit and whether the index had been loaded.
// Loads, clears and no-ops are taken one per cycle while the input is ready, which
// it is not while a query is in flight. A query's store read happens at its
// transfer; the five registered steps of the threshold pipeline (three multiply
// steps, one add, one final sum) and the output register follow, and the input
// is ready again only after the result is loaded, so queries do not overlap.
// The result waits in the output register while the receiver stalls; a
// following load or clear is still taken, and the next query waits in its
// last step until the output register is free.
// Reset clears the load count, the lower-right sums and the output valid and
// restores the configuration defaults. The store is not cleared; an unloaded index
// returns 0, index_valid 0. Configuration writes go through the plain write port;
// the user must make them only while no query is in flight; it is not enforced.
module qr_module_bit_classifier #(
  parameter int unsigned MAX_BITS = 32768
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // row[7:0], col[15:8], sample_a..sample_e[75:16], query_index[90:76], zero pad
  input  logic [qrbc_pkg::IN_TDATA_W-1:0]     s_tdata,
  // operation[1:0]
  input  logic [qrbc_pkg::OP_W-1:0]           s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // bit_value[0], index_valid[1], zero pad
  output logic [qrbc_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                                cfg_we,
  input  logic [qrbc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qrbc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import qrbc_pkg::*;

  cmd_t cmd;

  qrbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  qrbc_dp #(
    .MAX_BITS (MAX_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tdata   (m_tdata)
  );

endmodule
